>>> hdl/qwbr_pkg.sv
`default_nettype none
package qwbr_pkg;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] lin_x;
        logic signed [31:0] lin_y;
        logic signed [31:0] lin_z;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic        [31:0] tag;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] body_lin_x;
        logic signed [31:0] body_lin_y;
        logic signed [31:0] body_lin_z;
        logic signed [31:0] body_ang_x;
        logic signed [31:0] body_ang_y;
        logic signed [31:0] body_ang_z;
        logic        [31:0] tag_out;
    } out_item_t;

    localparam int ACC_W = 56;
    localparam int T_W   = 36;

    localparam logic KIND_POSE  = 1'b0;
    localparam logic KIND_TWIST = 1'b1;

    // mac / writeback operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_LD   = 3'd1;
    localparam logic [2:0] OP_LDV  = 3'd2;
    localparam logic [2:0] OP_ADD  = 3'd3;
    localparam logic [2:0] OP_SUB  = 3'd4;
    localparam logic [2:0] OP_WR_T = 3'd5;
    localparam logic [2:0] OP_WR_O = 3'd6;
    localparam logic [2:0] OP_WR_Q = 3'd7;

    // multiplier operand a
    localparam logic [2:0] A_W  = 3'd0;
    localparam logic [2:0] A_A0 = 3'd1;
    localparam logic [2:0] A_A1 = 3'd2;
    localparam logic [2:0] A_A2 = 3'd3;
    localparam logic [2:0] A_Q0 = 3'd4;
    localparam logic [2:0] A_Q1 = 3'd5;
    localparam logic [2:0] A_Q2 = 3'd6;
    localparam logic [2:0] A_Q3 = 3'd7;

    // multiplier operand b
    localparam logic [3:0] B_V0 = 4'd0;
    localparam logic [3:0] B_V1 = 4'd1;
    localparam logic [3:0] B_V2 = 4'd2;
    localparam logic [3:0] B_T0 = 4'd3;
    localparam logic [3:0] B_T1 = 4'd4;
    localparam logic [3:0] B_T2 = 4'd5;
    localparam logic [3:0] B_Q0 = 4'd6;
    localparam logic [3:0] B_Q1 = 4'd7;
    localparam logic [3:0] B_Q2 = 4'd8;
    localparam logic [3:0] B_Q3 = 4'd9;
    localparam logic [3:0] B_R  = 4'd10;

    localparam logic [5:0] N2_STEPS   = 6'd4;
    localparam logic [5:0] DIV_STEPS  = 6'd63;
    localparam logic [5:0] SQRT_STEPS = 6'd33;
    localparam logic [5:0] NRM_STEPS  = 6'd8;
    localparam logic [5:0] ROT_STEPS  = 6'd21;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] a_sel;
        logic [3:0] b_sel;
        logic [1:0] idx;
    } step_t;

    typedef struct packed {
        logic  load_in;
        step_t step;
        logic  vec;
        logic  div_init;
        logic  div_step;
        logic  sqrt_init;
        logic  sqrt_step;
        logic  publish;
    } cmd_t;

    function automatic step_t mk_step(input logic [2:0] op, input logic [2:0] a_sel,
                                      input logic [3:0] b_sel, input logic [1:0] idx);
        step_t s;
        s.op    = op;
        s.a_sel = a_sel;
        s.b_sel = b_sel;
        s.idx   = idx;
        return s;
    endfunction

    function automatic logic [2:0] a_of_q(input logic [1:0] i);
        logic [2:0] r;
        case (i)
            2'd0:    r = A_Q0;
            2'd1:    r = A_Q1;
            2'd2:    r = A_Q2;
            default: r = A_Q3;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] b_of_q(input logic [1:0] i);
        logic [3:0] r;
        case (i)
            2'd0:    r = B_Q0;
            2'd1:    r = B_Q1;
            2'd2:    r = B_Q2;
            default: r = B_Q3;
        endcase
        return r;
    endfunction

    // one vector: t = 2 (a x v), then out = v + w*t + a x t
    function automatic step_t rot_step(input logic [4:0] s);
        step_t r;
        unique case (s)
            5'd0:    r = mk_step(OP_LD,   A_A1, B_V2, 2'd0);
            5'd1:    r = mk_step(OP_SUB,  A_A2, B_V1, 2'd0);
            5'd2:    r = mk_step(OP_WR_T, A_W,  B_V0, 2'd0);
            5'd3:    r = mk_step(OP_LD,   A_A2, B_V0, 2'd0);
            5'd4:    r = mk_step(OP_SUB,  A_A0, B_V2, 2'd0);
            5'd5:    r = mk_step(OP_WR_T, A_W,  B_V0, 2'd1);
            5'd6:    r = mk_step(OP_LD,   A_A0, B_V1, 2'd0);
            5'd7:    r = mk_step(OP_SUB,  A_A1, B_V0, 2'd0);
            5'd8:    r = mk_step(OP_WR_T, A_W,  B_V0, 2'd2);
            5'd9:    r = mk_step(OP_LDV,  A_W,  B_T0, 2'd0);
            5'd10:   r = mk_step(OP_ADD,  A_A1, B_T2, 2'd0);
            5'd11:   r = mk_step(OP_SUB,  A_A2, B_T1, 2'd0);
            5'd12:   r = mk_step(OP_WR_O, A_W,  B_V0, 2'd0);
            5'd13:   r = mk_step(OP_LDV,  A_W,  B_T1, 2'd1);
            5'd14:   r = mk_step(OP_ADD,  A_A2, B_T0, 2'd0);
            5'd15:   r = mk_step(OP_SUB,  A_A0, B_T2, 2'd0);
            5'd16:   r = mk_step(OP_WR_O, A_W,  B_V0, 2'd1);
            5'd17:   r = mk_step(OP_LDV,  A_W,  B_T2, 2'd2);
            5'd18:   r = mk_step(OP_ADD,  A_A0, B_T1, 2'd0);
            5'd19:   r = mk_step(OP_SUB,  A_A1, B_T0, 2'd0);
            5'd20:   r = mk_step(OP_WR_O, A_W,  B_V0, 2'd2);
            default: r = mk_step(OP_NOP,  A_W,  B_V0, 2'd0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/qwbr_datapath.sv
`default_nettype none
module qwbr_datapath (
    input  wire logic                clk,
    input  wire qwbr_pkg::cmd_t      cmd,
    input  wire qwbr_pkg::in_item_t  in_data,
    output qwbr_pkg::out_item_t      out_data
);

    localparam int AW = qwbr_pkg::ACC_W;
    localparam int TW = qwbr_pkg::T_W;
    localparam logic signed [AW-1:0] S32_MAX = 56'sd2147483647;
    localparam logic signed [AW-1:0] S32_MIN = -56'sd2147483648;
    localparam logic signed [AW-1:0] Q_MAX   = 56'sd16384;
    localparam logic signed [AW-1:0] Q_MIN   = -56'sd16384;

    qwbr_pkg::in_item_t  in_reg;
    qwbr_pkg::out_item_t out_reg;
    logic signed [15:0]   uq_reg [4];
    logic signed [TW-1:0] t_reg  [3];
    logic signed [31:0]   o_reg  [2][3];
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [32:0] rem_reg;
    logic [62:0] quo_reg;
    logic [63:0] sq_n_reg, sq_r_reg, sq_bit_reg;

    logic signed [16:0]   a_op;
    logic signed [TW-1:0] b_op;
    logic signed [52:0]   prod;
    logic signed [AW-1:0] prod_ext, v_sh;
    logic signed [31:0]   v_sel [3];
    logic signed [AW-1:0] r_t, r_o, r_q;
    logic [33:0] trial;
    logic [63:0] sq_sum;

    function automatic logic signed [AW-1:0] rnd_sh(input logic signed [AW-1:0] a,
                                                    input int unsigned s);
        logic [AW-1:0] mag;
        logic [AW-1:0] half;
        half = {{(AW-1){1'b0}}, 1'b1} << (s - 1);
        mag  = a[AW-1] ? AW'(-a) : AW'(a);
        mag  = (mag + half) >> s;
        return a[AW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    always_comb
    begin
        if (cmd.vec)
        begin
            v_sel[0] = in_reg.ang_x;
            v_sel[1] = in_reg.ang_y;
            v_sel[2] = in_reg.ang_z;
        end
        else
        begin
            v_sel[0] = in_reg.lin_x;
            v_sel[1] = in_reg.lin_y;
            v_sel[2] = in_reg.lin_z;
        end
    end

    // the rotation uses a = -(x, y, z)
    always_comb
    begin
        case (cmd.step.a_sel)
            qwbr_pkg::A_W:  a_op = {uq_reg[0][15], uq_reg[0]};
            qwbr_pkg::A_A0: a_op = -{uq_reg[1][15], uq_reg[1]};
            qwbr_pkg::A_A1: a_op = -{uq_reg[2][15], uq_reg[2]};
            qwbr_pkg::A_A2: a_op = -{uq_reg[3][15], uq_reg[3]};
            qwbr_pkg::A_Q0: a_op = {in_reg.quat_w[15], in_reg.quat_w};
            qwbr_pkg::A_Q1: a_op = {in_reg.quat_x[15], in_reg.quat_x};
            qwbr_pkg::A_Q2: a_op = {in_reg.quat_y[15], in_reg.quat_y};
            default:        a_op = {in_reg.quat_z[15], in_reg.quat_z};
        endcase
    end

    always_comb
    begin
        case (cmd.step.b_sel)
            qwbr_pkg::B_V0: b_op = {{4{v_sel[0][31]}}, v_sel[0]};
            qwbr_pkg::B_V1: b_op = {{4{v_sel[1][31]}}, v_sel[1]};
            qwbr_pkg::B_V2: b_op = {{4{v_sel[2][31]}}, v_sel[2]};
            qwbr_pkg::B_T0: b_op = t_reg[0];
            qwbr_pkg::B_T1: b_op = t_reg[1];
            qwbr_pkg::B_T2: b_op = t_reg[2];
            qwbr_pkg::B_Q0: b_op = {{20{in_reg.quat_w[15]}}, in_reg.quat_w};
            qwbr_pkg::B_Q1: b_op = {{20{in_reg.quat_x[15]}}, in_reg.quat_x};
            qwbr_pkg::B_Q2: b_op = {{20{in_reg.quat_y[15]}}, in_reg.quat_y};
            qwbr_pkg::B_Q3: b_op = {{20{in_reg.quat_z[15]}}, in_reg.quat_z};
            qwbr_pkg::B_R:  b_op = {4'b0, sq_r_reg[31:0]};
            default:        b_op = '0;
        endcase
    end

    always_comb
    begin
        prod     = a_op * b_op;
        prod_ext = {{3{prod[52]}}, prod};
        case (cmd.step.idx)
            2'd0:    v_sh = {{10{v_sel[0][31]}}, v_sel[0], 14'b0};
            2'd1:    v_sh = {{10{v_sel[1][31]}}, v_sel[1], 14'b0};
            default: v_sh = {{10{v_sel[2][31]}}, v_sel[2], 14'b0};
        endcase
        case (cmd.step.op)
            qwbr_pkg::OP_LD:  acc_next = prod_ext;
            qwbr_pkg::OP_LDV: acc_next = v_sh + prod_ext;
            qwbr_pkg::OP_ADD: acc_next = acc_reg + prod_ext;
            qwbr_pkg::OP_SUB: acc_next = acc_reg - prod_ext;
            default:          acc_next = acc_reg;
        endcase
        r_t = rnd_sh(acc_reg, 13);
        r_o = rnd_sh(acc_reg, 14);
        r_q = rnd_sh(acc_reg, 17);
        // 2^62 / n2, numerator bits shifted in from the top of quo
        trial  = {rem_reg, quo_reg[62]};
        sq_sum = sq_r_reg + sq_bit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        acc_reg <= acc_next;
        case (cmd.step.op)
            qwbr_pkg::OP_WR_T: t_reg[cmd.step.idx] <= r_t[TW-1:0];
            qwbr_pkg::OP_WR_O:
            begin
                if (r_o > S32_MAX)
                    o_reg[cmd.vec][cmd.step.idx] <= S32_MAX[31:0];
                else if (r_o < S32_MIN)
                    o_reg[cmd.vec][cmd.step.idx] <= S32_MIN[31:0];
                else
                    o_reg[cmd.vec][cmd.step.idx] <= r_o[31:0];
            end
            qwbr_pkg::OP_WR_Q:
            begin
                if (r_q > Q_MAX)
                    uq_reg[cmd.step.idx] <= Q_MAX[15:0];
                else if (r_q < Q_MIN)
                    uq_reg[cmd.step.idx] <= Q_MIN[15:0];
                else
                    uq_reg[cmd.step.idx] <= r_q[15:0];
            end
            default: ;
        endcase
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= {1'b1, 62'b0};
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, acc_reg[32:0]})
            begin
                rem_reg <= 33'(trial - {1'b0, acc_reg[32:0]});
                quo_reg <= {quo_reg[61:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[61:0], 1'b0};
            end
        end
        if (cmd.sqrt_init)
        begin
            sq_n_reg   <= {1'b0, quo_reg};
            sq_r_reg   <= '0;
            sq_bit_reg <= {2'b01, 62'b0};
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_n_reg >= sq_sum)
            begin
                sq_n_reg <= sq_n_reg - sq_sum;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.publish)
        begin
            out_reg.body_lin_x <= o_reg[0][0];
            out_reg.body_lin_y <= o_reg[0][1];
            out_reg.body_lin_z <= o_reg[0][2];
            out_reg.body_ang_x <= o_reg[1][0];
            out_reg.body_ang_y <= o_reg[1][1];
            out_reg.body_ang_z <= o_reg[1][2];
            out_reg.tag_out    <= in_reg.tag;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

>>> hdl/qwbr_ctrl.sv
`default_nettype none
module qwbr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_kind,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    output qwbr_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_N2   = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_NRM  = 3'd4;
    localparam logic [2:0] S_ROT  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       pose_valid_reg, pose_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       last;
    logic [5:0] rot_idx;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg + 6'd1;
        pose_valid_next = pose_valid_reg;
        cmd             = '0;
        cmd.step        = qwbr_pkg::mk_step(qwbr_pkg::OP_NOP, qwbr_pkg::A_W,
                                            qwbr_pkg::B_V0, 2'd0);
        last            = 1'b0;
        rot_idx         = (cnt_reg >= qwbr_pkg::ROT_STEPS) ?
                          cnt_reg - qwbr_pkg::ROT_STEPS : cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    if (in_kind == qwbr_pkg::KIND_POSE)
                        state_next = S_N2;
                    else if (pose_valid_reg)
                        state_next = S_ROT;
                end
            end
            S_N2:
            begin
                cmd.step = qwbr_pkg::mk_step(
                    (cnt_reg == 6'd0) ? qwbr_pkg::OP_LD : qwbr_pkg::OP_ADD,
                    qwbr_pkg::a_of_q(cnt_reg[1:0]), qwbr_pkg::b_of_q(cnt_reg[1:0]),
                    cnt_reg[1:0]);
                last = (cnt_reg == qwbr_pkg::N2_STEPS - 6'd1);
                cmd.div_init = last;
                if (last)
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == qwbr_pkg::DIV_STEPS - 6'd1)
                begin
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_init = (cnt_reg == 6'd0);
                cmd.sqrt_step = (cnt_reg != 6'd0);
                if (cnt_reg == qwbr_pkg::SQRT_STEPS - 6'd1)
                begin
                    state_next = S_NRM;
                    cnt_next   = '0;
                end
            end
            S_NRM:
            begin
                // even: q_i * r, odd: round and store q_i
                cmd.step = qwbr_pkg::mk_step(
                    cnt_reg[0] ? qwbr_pkg::OP_WR_Q : qwbr_pkg::OP_LD,
                    qwbr_pkg::a_of_q(cnt_reg[2:1]), qwbr_pkg::B_R, cnt_reg[2:1]);
                if (cnt_reg == qwbr_pkg::NRM_STEPS - 6'd1)
                begin
                    pose_valid_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_ROT:
            begin
                cmd.vec  = (cnt_reg >= qwbr_pkg::ROT_STEPS);
                cmd.step = qwbr_pkg::rot_step(rot_idx[4:0]);
                if (cnt_reg == {qwbr_pkg::ROT_STEPS[4:0], 1'b0} - 6'd1)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pose_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pose_valid_reg <= pose_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
        else $error("result published over a pending item");

    a_no_pose_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == qwbr_pkg::KIND_TWIST && !pose_valid_reg)
        |=> (state_reg == S_IDLE))
        else $error("twist before pose was not dropped");

    a_pose_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NRM && cnt_reg == qwbr_pkg::NRM_STEPS - 6'd1) |=> pose_valid_reg)
        else $error("pose flag not set after normalization");

    a_pose_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid_reg |=> pose_valid_reg)
        else $error("pose flag cleared outside reset");

endmodule
`default_nettype wire

>>> hdl/quaternion_world_to_body_rotation.sv
// quaternion world-to-body twist rotation
// input channel in_valid / in_stall / in_data carries pose items (kind 0) and
// twist items (kind 1); output channel out_valid / out_stall / out_data carries
// body-frame velocities and the tag of each twist.
// a pose item is normalized through a shared 17x36 multiply-accumulate unit,
// a bit-serial divider (2^62 / |q|^2) and a bit-serial square root; the block
// is busy through its norm, divide, root and normalize states and gives no result.
// a twist item runs 42 steps of the same multiply-accumulate unit (21 per
// vector); its result becomes valid as the block returns to idle, and the next
// item is taken from that cycle on. the multiplier sets the twist rate, the
// one-bit-per-cycle divider and root set the pose rate.
// a twist taken before any pose is dropped, and the block is ready next cycle.
// reset clears the controller, the pose flag and the output valid; the stored
// quaternion is undefined until the first pose.
// a stalled result holds in the output register; a finished twist waits in its
// result registers until the slot frees, and no new item is taken meanwhile.
`default_nettype none
module quaternion_world_to_body_rotation (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire qwbr_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output qwbr_pkg::out_item_t       out_data
);

    qwbr_pkg::cmd_t cmd;

    qwbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (in_data.kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    qwbr_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

class twist_scoreboard;
    // stored unit quaternion and pose flag, mirrored from accepted items
    logic signed [63:0]   unit_q [4];
    bit                   have_pose;
    qwbr_pkg::out_item_t  pending [$];
    int                   mismatches;

    function new();
        have_pose = 0;
        mismatches = 0;
        foreach (unit_q[i]) unit_q[i] = 0;
    endfunction

    static function logic signed [63:0] round_shift(logic signed [63:0] a, int s);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (s - 1);
        if (a < 0)
        begin
            mag = -a;
            return -$signed((mag + half) >> s);
        end
        mag = a;
        return $signed((mag + half) >> s);
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function void store_pose(qwbr_pkg::in_item_t it);
        logic signed [63:0] q [4];
        logic [63:0]        n2;
        logic signed [63:0] r;
        logic signed [63:0] c;
        q[0] = it.quat_w;
        q[1] = it.quat_x;
        q[2] = it.quat_y;
        q[3] = it.quat_z;
        n2 = 0;
        foreach (q[i]) n2 = n2 + q[i] * q[i];
        if (n2 == 0)
            foreach (unit_q[i]) unit_q[i] = 0;
        else
        begin
            r = int_sqrt((64'd1 << 62) / n2);
            foreach (q[i])
            begin
                c = round_shift(q[i] * r, 17);
                if (c > 16384) c = 16384;
                if (c < -16384) c = -16384;
                unit_q[i] = c;
            end
        end
        have_pose = 1;
    endfunction

    function void rotate_back(input logic signed [63:0] v [3],
                              output logic signed [31:0] o [3]);
        logic signed [63:0] a [3];
        logic signed [63:0] c [3];
        logic signed [63:0] t [3];
        logic signed [63:0] d [3];
        logic signed [63:0] s;
        for (int i = 0; i < 3; i++) a[i] = -unit_q[i + 1];
        c[0] = a[1] * v[2] - a[2] * v[1];
        c[1] = a[2] * v[0] - a[0] * v[2];
        c[2] = a[0] * v[1] - a[1] * v[0];
        for (int i = 0; i < 3; i++) t[i] = round_shift(2 * c[i], 14);
        d[0] = a[1] * t[2] - a[2] * t[1];
        d[1] = a[2] * t[0] - a[0] * t[2];
        d[2] = a[0] * t[1] - a[1] * t[0];
        for (int i = 0; i < 3; i++)
        begin
            s = round_shift(v[i] * 16384 + unit_q[0] * t[i] + d[i], 14);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            o[i] = s[31:0];
        end
    endfunction

    function void note_input(qwbr_pkg::in_item_t it);
        logic signed [63:0]  lv [3];
        logic signed [63:0]  av [3];
        logic signed [31:0]  lo [3];
        logic signed [31:0]  ao [3];
        qwbr_pkg::out_item_t e;
        if (it.kind == qwbr_pkg::KIND_POSE)
        begin
            store_pose(it);
            return;
        end
        if (!have_pose) return;
        lv[0] = it.lin_x; lv[1] = it.lin_y; lv[2] = it.lin_z;
        av[0] = it.ang_x; av[1] = it.ang_y; av[2] = it.ang_z;
        rotate_back(lv, lo);
        rotate_back(av, ao);
        e.body_lin_x = lo[0]; e.body_lin_y = lo[1]; e.body_lin_z = lo[2];
        e.body_ang_x = ao[0]; e.body_ang_y = ao[1]; e.body_ang_z = ao[2];
        e.tag_out = it.tag;
        pending.push_back(e);
    endfunction

    function void check_result(qwbr_pkg::out_item_t got);
        qwbr_pkg::out_item_t e;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        e = pending.pop_front();
        if (got !== e)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h got %h", e, got);
        end
    endfunction
endclass

module testbench;
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    qwbr_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    qwbr_pkg::out_item_t out_data;

    twist_scoreboard board;
    int  hold_cycles;   // long receiver hold-off, counted in the stall process
    bit  stim_done;

    quaternion_world_to_body_rotation dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic signed [15:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_v();
        case ($urandom_range(0, 7))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 32'sd0;
            3: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic qwbr_pkg::in_item_t rand_item(logic k);
        qwbr_pkg::in_item_t it;
        it.kind = k;
        it.quat_w = rand_q(); it.quat_x = rand_q();
        it.quat_y = rand_q(); it.quat_z = rand_q();
        it.lin_x = rand_v(); it.lin_y = rand_v(); it.lin_z = rand_v();
        it.ang_x = rand_v(); it.ang_y = rand_v(); it.ang_z = rand_v();
        it.tag = $urandom;
        return it;
    endfunction

    // valid stays high between back-to-back items and drops only for a gap or a drain
    task automatic send(qwbr_pkg::in_item_t it, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        board.note_input(it);
    endtask

    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        qwbr_pkg::in_item_t it;
        it = rand_item(qwbr_pkg::KIND_POSE);
        it.quat_w = w; it.quat_x = x; it.quat_y = y; it.quat_z = z;
        send(it, 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stim_done)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        qwbr_pkg::in_item_t it;
        logic               k;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_cycles = 0;
        stim_done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // twist before any pose is dropped
        send(rand_item(qwbr_pkg::KIND_TWIST), 0);
        send(rand_item(qwbr_pkg::KIND_TWIST), 1);
        // zero quaternion passes twists through
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        it = rand_item(qwbr_pkg::KIND_TWIST);
        it.lin_x = 32'sh7fffffff; it.lin_y = 32'sh80000000; it.lin_z = 32'sd0;
        it.ang_x = 32'sh80000000; it.ang_y = 32'sh7fffffff; it.ang_z = -32'sd1;
        it.tag = 32'hffffffff;
        send(it, 0);
        send_quat(16'sh4000, 16'sd0, 16'sd0, 16'sd0);
        send(it, 0);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send(it, 0);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send(it, 0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd1);
        it.tag = 32'h0;
        send(it, 0);
        send_quat(16'sh2d41, 16'sh2d41, 16'sd0, 16'sd0);
        it.lin_x = 32'sh80000000; it.lin_y = 32'sh80000000; it.lin_z = 32'sh80000000;
        send(it, 0);
        send_quat(16'sd0, 16'sh8000, 16'sd0, 16'sh7fff);
        send(rand_item(qwbr_pkg::KIND_TWIST), 0);
        send(rand_item(qwbr_pkg::KIND_TWIST), 0);

        // sender pauses until everything has come out
        drain();

        for (int n = 0; n < 1530; n++)
        begin
            if (n == 400)
                hold_cycles = 600;
            if (n == 900)
                drain();
            k = ($urandom_range(0, 9) < 2) ? qwbr_pkg::KIND_POSE : qwbr_pkg::KIND_TWIST;
            send(rand_item(k), (n >= 400 && n < 420) ? 0 : pick_gap());
        end

        stim_done = 1;
        drain();
        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
